@@ src/sr_pkg.sv @@
// shared types and constants of the selective-repeat receiver
// no dependencies
package sr_pkg;

    localparam int CFG_DATA_BITS  = 9;
    localparam int CFG_INDEX_BITS = 1;
    localparam int MOD_REG_BITS   = 9;
    localparam int WIN_REG_BITS   = 5;
    localparam int ACK_BITS       = 8;

    localparam logic [MOD_REG_BITS-1:0] MOD_RESET = 9'd8;
    localparam logic [WIN_REG_BITS-1:0] WIN_RESET = 5'd4;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_MODULUS = 1'b0,
        CFG_WINDOW  = 1'b1
    } cfg_index_t;

    typedef enum logic [0:0] {
        KIND_DELIVER = 1'b0,
        KIND_ACK     = 1'b1
    } result_kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REM,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctl_t;

endpackage

@@ src/sr_rem.sv @@
// remainder unit: x mod m, one bit per cycle, restoring
// skips the iteration when x is already below m; uses sr_pkg
module sr_rem
    import sr_pkg::*;
#(
    parameter int W = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] x,
    input  logic [W:0]   m,
    output logic         busy,
    output logic [W-1:0] r
);

    localparam int CNTW = $clog2(W + 1);

    logic            busy_reg, busy_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]    r_reg, r_next;
    logic [W-1:0]    x_reg, x_next;
    logic [W:0]      trial;
    logic [W:0]      diff;

    assign trial = {r_reg, x_reg[W-1]};
    assign diff  = trial - m;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        r_next    = r_reg;
        x_next    = x_reg;
        if (start)
        begin
            if ({1'b0, x} < m)
            begin
                r_next = x;
            end
            else
            begin
                r_next    = '0;
                x_next    = x;
                cnt_next  = CNTW'(W);
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            r_next   = (trial >= m) ? diff[W-1:0] : trial[W-1:0];
            x_next   = x_reg << 1;
            cnt_next = cnt_reg - CNTW'(1);
            if (cnt_reg == CNTW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        r_reg <= r_next;
        x_reg <= x_next;
    end

    assign busy = busy_reg;
    assign r    = r_reg;

endmodule

@@ src/sr_cell.sv @@
// one buffer cell of the receive window chain
// holds a filled flag and a payload, loads a request or takes its neighbour's content; uses sr_pkg
module sr_cell
    import sr_pkg::*;
#(
    parameter int PAYLOAD_BITS = 32
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  cell_ctl_t               ctl,
    input  logic                    fill_in,
    input  logic [PAYLOAD_BITS-1:0] word_in,
    input  logic [PAYLOAD_BITS-1:0] wr_word,
    output logic                    filled,
    output logic [PAYLOAD_BITS-1:0] word
);

    logic                    filled_reg, filled_next;
    logic [PAYLOAD_BITS-1:0] payload_reg, payload_next;

    always_comb
    begin
        filled_next  = filled_reg;
        payload_next = payload_reg;
        priority if (ctl.load)
        begin
            filled_next  = 1'b1;
            payload_next = wr_word;
        end
        else if (ctl.shift)
        begin
            filled_next  = fill_in;
            payload_next = word_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filled_reg <= 1'b0;
        end
        else
        begin
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
    end

    assign filled = filled_reg;
    assign word   = payload_reg;

endmodule

@@ src/selective_repeat_receiver_top.sv @@
// selective-repeat receiver top level: sequencer, window cell chain, remainder units
// uses sr_pkg, sr_rem, sr_cell
//
// channel   direction  handshake                 contents
// request   in         start & !busy             seq_num, payload_word, checksum_ok
// result    out        result_valid, one cycle   result_kind, delivered_word, ack_num, last
// config    in         cfg_we                    cfg_index, cfg_data
//
// busy stays high after a request is taken while the remainders are formed and its payloads are delivered;
// when seq_num or the base is at or above the modulus the remainder units first run their restoring iterations
// delivery drains the cell chain one slot a cycle; a bad checksum request is dropped at once
// reset clears the filled flags, the base and the sequencer; there is no clearing pass
// results cannot be stalled; each is shown for exactly one cycle
module selective_repeat_receiver_top
    import sr_pkg::*;
#(
    parameter int MAX_WINDOW   = 16,
    parameter int SEQ_BITS     = 8,
    parameter int PAYLOAD_BITS = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [SEQ_BITS-1:0]       seq_num,
    input  logic [PAYLOAD_BITS-1:0]   payload_word,
    input  logic                      checksum_ok,
    output logic                      result_valid,
    output logic                      result_kind,
    output logic [PAYLOAD_BITS-1:0]   delivered_word,
    output logic [ACK_BITS-1:0]       ack_num,
    output logic                      last,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int MW  = SEQ_BITS + 1;
    localparam int CW  = (MW > MOD_REG_BITS) ? MW : MOD_REG_BITS;
    localparam int WWA = $clog2(MAX_WINDOW + 1);
    localparam int WW  = (WWA > WIN_REG_BITS) ? WWA : WIN_REG_BITS;
    localparam int XW  = (MW > WW) ? MW : WW;

    // configuration
    logic [MOD_REG_BITS-1:0] modulus_reg;
    logic [WIN_REG_BITS-1:0] window_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= MOD_RESET;
            window_reg  <= WIN_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_MODULUS: modulus_reg <= cfg_data[MOD_REG_BITS-1:0];
                CFG_WINDOW:  window_reg  <= cfg_data[WIN_REG_BITS-1:0];
            endcase
        end
    end

    // effective modulus and window
    logic [CW-1:0] mod_ext;
    logic [CW-1:0] mod_top;
    logic [CW-1:0] mod_clamp;
    logic [MW-1:0] mod_eff;
    logic [WW-1:0] win_ext;
    logic [WW-1:0] win_eff;

    assign mod_ext   = CW'(modulus_reg);
    assign mod_top   = CW'(1) << SEQ_BITS;
    assign mod_clamp = (mod_ext < CW'(2)) ? CW'(2) :
                       (mod_ext > mod_top) ? mod_top : mod_ext;
    assign mod_eff   = mod_clamp[MW-1:0];
    assign win_ext   = WW'(window_reg);
    assign win_eff   = (win_ext > WW'(MAX_WINDOW)) ? WW'(MAX_WINDOW) : win_ext;

    // sequencer state
    state_t                  state_reg, state_next;
    logic [SEQ_BITS-1:0]     base_reg, base_next;
    logic [SEQ_BITS-1:0]     seq_reg, seq_next;
    logic [PAYLOAD_BITS-1:0] word_reg, word_next;
    logic                    valid_reg, valid_next;
    result_kind_t            kind_reg, kind_next;
    logic [PAYLOAD_BITS-1:0] dword_reg, dword_next;
    logic [ACK_BITS-1:0]     ack_reg, ack_next;
    logic                    last_reg, last_next;

    // remainder units
    logic                rem_start;
    logic                rem_busy_s;
    logic                rem_busy_b;
    logic [SEQ_BITS-1:0] rs;
    logic [SEQ_BITS-1:0] rb;

    sr_rem #(.W(SEQ_BITS)) u_rem_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rem_start),
        .x     (seq_num),
        .m     (mod_eff),
        .busy  (rem_busy_s),
        .r     (rs)
    );

    sr_rem #(.W(SEQ_BITS)) u_rem_base (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rem_start),
        .x     (base_reg),
        .m     (mod_eff),
        .busy  (rem_busy_b),
        .r     (rb)
    );

    // offset from the base and slot selection
    logic [MW-1:0]         off;
    logic                  in_win;
    logic [MAX_WINDOW-1:0] sel_vec;
    logic [MAX_WINDOW-1:0] filled_vec;
    logic                  slot_taken;
    logic [MAX_WINDOW-1:0] load_vec;
    logic                  shift_all;

    logic [PAYLOAD_BITS-1:0] word_vec [MAX_WINDOW];
    cell_ctl_t               ctl_vec  [MAX_WINDOW];

    assign off = (rs >= rb) ? (MW'(rs) - MW'(rb)) : (MW'(rs) + mod_eff - MW'(rb));
    assign in_win     = XW'(off) < XW'(win_eff);
    assign slot_taken = |(filled_vec & sel_vec);

    // window cell chain, cell k holds offset k from the base
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic                    fill_in;
        logic [PAYLOAD_BITS-1:0] word_in;

        assign sel_vec[i]       = XW'(off) == XW'(i);
        assign ctl_vec[i].load  = load_vec[i];
        assign ctl_vec[i].shift = shift_all;

        if (i == MAX_WINDOW - 1)
        begin : g_end
            assign fill_in = 1'b0;
            assign word_in = '0;
        end
        else
        begin : g_mid
            assign fill_in = filled_vec[i+1];
            assign word_in = word_vec[i+1];
        end

        sr_cell #(.PAYLOAD_BITS(PAYLOAD_BITS)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl_vec[i]),
            .fill_in (fill_in),
            .word_in (word_in),
            .wr_word (word_reg),
            .filled  (filled_vec[i]),
            .word    (word_vec[i])
        );
    end

    // base advance, wrapping at the modulus
    logic [MW-1:0]       base_plus;
    logic [SEQ_BITS-1:0] base_inc;

    assign base_plus = MW'(base_reg) + MW'(1);
    assign base_inc  = (base_plus == mod_eff) ? '0 : base_plus[SEQ_BITS-1:0];

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        seq_next   = seq_reg;
        word_next  = word_reg;
        rem_start  = 1'b0;
        load_vec   = '0;
        shift_all  = 1'b0;
        valid_next = 1'b0;
        kind_next  = KIND_ACK;
        dword_next = '0;
        ack_next   = '0;
        last_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start && checksum_ok)
                begin
                    rem_start  = 1'b1;
                    seq_next   = seq_num;
                    word_next  = payload_word;
                    state_next = ST_REM;
                end
            end
            ST_REM:
            begin
                if (!rem_busy_s && !rem_busy_b)
                begin
                    if (in_win && !slot_taken)
                    begin
                        load_vec = sel_vec;
                        // here the base is set to its remainder only when the slot at the base gets filled
                        if (off == '0)
                        begin
                            base_next = rb;
                        end
                    end
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                valid_next = 1'b1;
                if (filled_vec[0])
                begin
                    shift_all  = 1'b1;
                    kind_next  = KIND_DELIVER;
                    dword_next = word_vec[0];
                    base_next  = base_inc;
                end
                else
                begin
                    ack_next   = ACK_BITS'(seq_reg);
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            base_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg   <= seq_next;
        word_reg  <= word_next;
        kind_reg  <= kind_next;
        dword_reg <= dword_next;
        ack_reg   <= ack_next;
        last_reg  <= last_next;
    end

    assign busy           = state_reg != ST_IDLE;
    assign result_valid   = valid_reg;
    assign result_kind    = kind_reg;
    assign delivered_word = dword_reg;
    assign ack_num        = ack_reg;
    assign last           = last_reg;

    // a delivery is always followed by more results of the same request
    a_deliver_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !last_reg) |-> busy)
        else $error("delivery shown with the sequencer idle");

    // the acknowledgement closes a request and is never followed at once by another result
    a_ack_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && last_reg) |=> !valid_reg)
        else $error("result directly after an acknowledgement");

    // draining always empties the slot at the base
    a_base_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REM) |-> !filled_vec[0])
        else $error("slot at the base still filled at a new request");

    // a good request always starts work
    a_take: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && checksum_ok) |=> busy)
        else $error("good request not taken");

endmodule
